### sv/rfeu_pkg.sv
// ----------------------------------------------------------------------------
// rfeu_pkg: shared types and codes of the register frame execute unit
// Operation and status codes, default frame size and the queued op record.
// ----------------------------------------------------------------------------
`default_nettype none
package rfeu_pkg;

  // operation kinds
  localparam logic [3:0] K_NOP  = 4'd0;
  localparam logic [3:0] K_MOV  = 4'd1;
  localparam logic [3:0] K_MOVR = 4'd2;
  localparam logic [3:0] K_SWAP = 4'd3;
  localparam logic [3:0] K_LDI  = 4'd4;
  localparam logic [3:0] K_ADD  = 4'd5;
  localparam logic [3:0] K_SUB  = 4'd6;
  localparam logic [3:0] K_MUL  = 4'd7;
  localparam logic [3:0] K_DIV  = 4'd8;
  localparam logic [3:0] K_MOD  = 4'd9;
  localparam logic [3:0] K_NEG  = 4'd10;
  localparam logic [3:0] K_RET  = 4'd11;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIVZ  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_RET   = 2'd3;

  // default frame size, and the width used for index and range compares
  localparam int FRAME_REGS_DEF = 256;
  localparam int CMP_W          = 18;

  // classified operation as it travels from front to back
  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  status;
    logic        desc;
    logic [7:0]  d;
    logic [7:0]  s;
    logic [7:0]  s2;
    logic [8:0]  cnt;
    logic [15:0] imm;
  } op_t;

endpackage
`default_nettype wire

### sv/rfeu_front.sv
// ----------------------------------------------------------------------------
// rfeu_front: instruction intake and classification
// Accepts input transactions, checks indexes and ranges against the frame
// and pushes one classified op into the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module rfeu_front #(
  parameter int FRAME_REGS = rfeu_pkg::FRAME_REGS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [3:0]           in_kind,
  input  wire  [7:0]           in_dest_index,
  input  wire  [7:0]           in_src_index,
  input  wire  [7:0]           in_src2_index,
  input  wire  [8:0]           in_move_count,
  input  wire  [15:0]          in_immediate,
  input  wire                  clr_busy,
  input  wire                  q_ready,
  output logic                 q_push,
  output rfeu_pkg::op_t        q_op
);

  localparam logic [rfeu_pkg::CMP_W-1:0] FR = rfeu_pkg::CMP_W'(FRAME_REGS);

  logic [rfeu_pkg::CMP_W-1:0] d_w, s_w, s2_w, cnt_w;
  logic [3:0] kind;
  logic need_d, need_s, need_s2, bad;
  logic seen_rst_r;

  // track reset for the accept gate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_rst_r <= 1'b1;
    end else begin
      seen_rst_r <= 1'b0;
    end
  end

  // hold intake while the frame is being cleared or the queue is full
  assign in_ready = q_ready && !clr_busy && !seen_rst_r;
  assign q_push   = in_valid && in_ready;

  // classify the instruction
  always_comb begin
    d_w   = rfeu_pkg::CMP_W'(in_dest_index);
    s_w   = rfeu_pkg::CMP_W'(in_src_index);
    s2_w  = rfeu_pkg::CMP_W'(in_src2_index);
    cnt_w = rfeu_pkg::CMP_W'(in_move_count);
    kind  = (in_kind > rfeu_pkg::K_RET) ? rfeu_pkg::K_NOP : in_kind;
    need_d  = (kind == rfeu_pkg::K_MOV) || (kind == rfeu_pkg::K_SWAP) ||
              (kind == rfeu_pkg::K_LDI) || (kind >= rfeu_pkg::K_ADD);
    need_s  = (kind == rfeu_pkg::K_MOV) || (kind == rfeu_pkg::K_SWAP) ||
              ((kind >= rfeu_pkg::K_ADD) && (kind <= rfeu_pkg::K_NEG));
    need_s2 = (kind >= rfeu_pkg::K_ADD) && (kind <= rfeu_pkg::K_MOD);
    if (kind == rfeu_pkg::K_MOVR) begin
      bad = (d_w + cnt_w > FR) || (s_w + cnt_w > FR);
    end else begin
      bad = (need_d && !(d_w < FR)) || (need_s && !(s_w < FR)) ||
            (need_s2 && !(s2_w < FR));
    end
    q_op.kind   = kind;
    q_op.status = bad ? rfeu_pkg::ST_RANGE : rfeu_pkg::ST_OK;
    q_op.desc   = in_dest_index > in_src_index;
    q_op.d      = in_dest_index;
    q_op.s      = in_src_index;
    q_op.s2     = in_src2_index;
    q_op.cnt    = in_move_count;
    q_op.imm    = in_immediate;
  end

endmodule
`default_nettype wire

### sv/rfeu_queue.sv
// ----------------------------------------------------------------------------
// rfeu_queue: two-entry op queue
// Decouples intake from execution so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none
module rfeu_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  rfeu_pkg::op_t  push_op,
  output logic           push_ready,
  input  wire            pop,
  output logic           pop_valid,
  output rfeu_pkg::op_t  pop_op
);

  rfeu_pkg::op_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_op     = ent_r[rp_r];

  // store entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_op;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop && pop_valid) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop && pop_valid};
    end
  end

endmodule
`default_nettype wire

### sv/rfeu_back.sv
// ----------------------------------------------------------------------------
// rfeu_back: execution sequencer and register frame
// Owns the frame memory, clears it after reset, executes queued ops with a
// shared 32x32 multiplier and a bit-serial divider, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none
module rfeu_back #(
  parameter int FRAME_REGS = rfeu_pkg::FRAME_REGS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  input  rfeu_pkg::op_t       q_op,
  output logic                q_pop,
  output logic                clr_busy,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [1:0]          out_status,
  output logic signed [63:0]  out_result_value
);

  localparam int AW = $clog2(FRAME_REGS);
  localparam int CW = rfeu_pkg::CMP_W;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_EX   = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_DFIX = 4'd5;
  localparam logic [3:0] S_MVRD = 4'd6;
  localparam logic [3:0] S_MVWR = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  function automatic logic [63:0] mag(input logic [63:0] x);
    mag = x[63] ? (64'd0 - x) : x;
  endfunction

  logic [63:0] mem [FRAME_REGS];
  logic [63:0] rda_r, rdb_r;
  logic [AW-1:0] ra, rb, wa;
  logic [63:0] wd;
  logic we;

  logic [3:0]  state_r, state_nxt;
  logic [AW-1:0] clr_r;
  rfeu_pkg::op_t cur_r;
  logic [1:0]  st_r;
  logic [63:0] val_r;
  logic        wr_r;
  logic [AW-1:0] src_r, dst_r;
  logic [8:0]  mvc_r;
  logic [63:0] opa_r, opb_r, prod_r, acc_r;
  logic [1:0]  mcnt_r;
  logic [63:0] dq_r, rem_r, dv_r;
  logic [5:0]  dcnt_r;
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [63:0] out_value_r;
  logic        can_out;
  logic [31:0] mx, my;
  logic [63:0] mp;
  logic [64:0] rsh;
  logic        qbit;
  logic [CW-1:0] s_end, d_end;

  assign clr_busy         = state_r == S_CLR;
  assign can_out          = !out_valid_r || out_ready;
  assign q_pop            = (state_r == S_IDLE) && q_valid;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;

  // frame memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda_r <= mem[ra];
    rdb_r <= mem[rb];
  end

  // memory port steering
  always_comb begin
    ra = src_r;
    rb = AW'(q_op.s2);
    we = 1'b0;
    wa = clr_r;
    wd = 64'd0;
    if (state_r == S_IDLE) begin
      ra = AW'(q_op.s);
      if ((q_op.kind == rfeu_pkg::K_SWAP) || (q_op.kind == rfeu_pkg::K_RET)) begin
        rb = AW'(q_op.d);
      end
    end
    case (state_r)
      S_CLR: begin
        we = 1'b1;
      end
      S_EX: begin
        if (cur_r.kind == rfeu_pkg::K_SWAP) begin
          we = 1'b1;
          wa = AW'(cur_r.s);
          wd = rdb_r;
        end
      end
      S_MVWR: begin
        we = 1'b1;
        wa = dst_r;
        wd = rda_r;
      end
      S_DONE: begin
        we = can_out && wr_r;
        wa = AW'(cur_r.d);
        wd = val_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // multiplier operand select and divider step
  always_comb begin
    mx = (mcnt_r == 2'd2) ? opa_r[63:32] : opa_r[31:0];
    my = (mcnt_r == 2'd1) ? opb_r[63:32] : opb_r[31:0];
    mp = mx * my;
    rsh  = {rem_r, dq_r[63]};
    qbit = rsh >= {1'b0, dv_r};
    s_end = CW'(q_op.s) + CW'(q_op.cnt) - CW'(1);
    d_end = CW'(q_op.d) + CW'(q_op.cnt) - CW'(1);
  end

  // sequence next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (clr_r == AW'(FRAME_REGS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          if ((q_op.status != rfeu_pkg::ST_OK) || (q_op.kind == rfeu_pkg::K_NOP) ||
              (q_op.kind == rfeu_pkg::K_LDI)) begin
            state_nxt = S_DONE;
          end else if (q_op.kind == rfeu_pkg::K_MOVR) begin
            state_nxt = (q_op.cnt == 9'd0) ? S_DONE : S_MVRD;
          end else begin
            state_nxt = S_EX;
          end
        end
      end
      S_EX: begin
        if (cur_r.kind == rfeu_pkg::K_MUL) begin
          state_nxt = S_MUL;
        end else if (((cur_r.kind == rfeu_pkg::K_DIV) || (cur_r.kind == rfeu_pkg::K_MOD)) &&
                     (rdb_r != 64'd0)) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        if (mcnt_r == 2'd3) begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (dcnt_r == 6'd63) begin
          state_nxt = S_DFIX;
        end
      end
      S_DFIX: begin
        state_nxt = S_DONE;
      end
      S_MVRD: begin
        state_nxt = S_MVWR;
      end
      S_MVWR: begin
        state_nxt = (mvc_r == 9'd1) ? S_DONE : S_MVRD;
      end
      S_DONE: begin
        if (can_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_r <= clr_r + AW'(1);
      end
      if ((state_r == S_DONE) && can_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cur_r <= q_op;
        st_r  <= q_op.status;
        val_r <= 64'd0;
        wr_r  <= 1'b0;
        mvc_r <= q_op.cnt;
        if (q_op.desc) begin
          src_r <= AW'(s_end);
          dst_r <= AW'(d_end);
        end else begin
          src_r <= AW'(q_op.s);
          dst_r <= AW'(q_op.d);
        end
        if ((q_op.status == rfeu_pkg::ST_OK) && (q_op.kind == rfeu_pkg::K_LDI)) begin
          val_r <= {48'd0, q_op.imm};
          wr_r  <= 1'b1;
        end
      end
      S_EX: begin
        opa_r  <= rda_r;
        opb_r  <= rdb_r;
        mcnt_r <= 2'd0;
        dcnt_r <= 6'd0;
        dq_r   <= mag(rda_r);
        dv_r   <= mag(rdb_r);
        rem_r  <= 64'd0;
        wr_r   <= 1'b1;
        case (cur_r.kind)
          rfeu_pkg::K_MOV:  val_r <= rda_r;
          rfeu_pkg::K_SWAP: val_r <= rda_r;
          rfeu_pkg::K_ADD:  val_r <= rda_r + rdb_r;
          rfeu_pkg::K_SUB:  val_r <= rda_r - rdb_r;
          rfeu_pkg::K_NEG:  val_r <= 64'd0 - rda_r;
          rfeu_pkg::K_RET: begin
            val_r <= rdb_r;
            st_r  <= rfeu_pkg::ST_RET;
            wr_r  <= 1'b0;
          end
          rfeu_pkg::K_DIV, rfeu_pkg::K_MOD: begin
            if (rdb_r == 64'd0) begin
              st_r <= rfeu_pkg::ST_DIVZ;
              wr_r <= 1'b0;
            end
          end
          default: begin
            val_r <= 64'd0;
          end
        endcase
      end
      S_MUL: begin
        // one 32x32 partial product per cycle, accumulate the one before
        mcnt_r <= mcnt_r + 2'd1;
        prod_r <= mp;
        case (mcnt_r)
          2'd0:    acc_r <= 64'd0;
          2'd1:    acc_r <= prod_r;
          2'd2:    acc_r <= acc_r + {prod_r[31:0], 32'd0};
          default: val_r <= acc_r + {prod_r[31:0], 32'd0};
        endcase
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        dcnt_r <= dcnt_r + 6'd1;
        dq_r   <= {dq_r[62:0], qbit};
        rem_r  <= qbit ? 64'(rsh - {1'b0, dv_r}) : rsh[63:0];
      end
      S_DFIX: begin
        if (cur_r.kind == rfeu_pkg::K_DIV) begin
          val_r <= (opa_r[63] ^ opb_r[63]) ? (64'd0 - dq_r) : dq_r;
        end else begin
          val_r <= opa_r[63] ? (64'd0 - rem_r) : rem_r;
        end
      end
      S_MVWR: begin
        mvc_r <= mvc_r - 9'd1;
        if (cur_r.desc) begin
          src_r <= src_r - AW'(1);
          dst_r <= dst_r - AW'(1);
        end else begin
          src_r <= src_r + AW'(1);
          dst_r <= dst_r + AW'(1);
        end
      end
      S_DONE: begin
        if (can_out) begin
          out_status_r <= st_r;
          out_value_r  <= val_r;
        end
      end
      default: begin
        val_r <= val_r;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/register_frame_execute_unit.sv
// ----------------------------------------------------------------------------
// register_frame_execute_unit: register-machine execute stage
// Executes one instruction per input transaction against a frame of 64-bit
// registers and returns one status/value result per instruction.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_ready  | kind, indexes, move count, imm
//  out_    | output    | out_valid/out_ready| status, result_value
//
//  nop, ldi and range errors skip execution; mov, add, sub, neg, swap
//  and return pass one execute state; mul makes four passes over one 32x32
//  multiplier; div and mod use a bit-serial divider; a range move alternates
//  a read and a write per register. Reset: the frame is cleared one register
//  per cycle, with in_ready low throughout. A two-entry queue lets intake
//  run ahead; a held result stalls execution, and intake once it is full.
// ----------------------------------------------------------------------------
`default_nettype none
module register_frame_execute_unit #(
  parameter int FRAME_REGS = rfeu_pkg::FRAME_REGS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [3:0]          in_kind,
  input  wire  [7:0]          in_dest_index,
  input  wire  [7:0]          in_src_index,
  input  wire  [7:0]          in_src2_index,
  input  wire  [8:0]          in_move_count,
  input  wire  [15:0]         in_immediate,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [1:0]          out_status,
  output logic signed [63:0]  out_result_value
);

  rfeu_pkg::op_t push_op, pop_op;
  logic push, push_ready, pop, pop_valid, clr_busy;

  // intake and classify
  rfeu_front #(.FRAME_REGS(FRAME_REGS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_dest_index(in_dest_index),
    .in_src_index(in_src_index), .in_src2_index(in_src2_index),
    .in_move_count(in_move_count), .in_immediate(in_immediate),
    .clr_busy(clr_busy), .q_ready(push_ready),
    .q_push(push), .q_op(push_op)
  );

  // decouple intake from execution
  rfeu_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_op(push_op), .push_ready(push_ready),
    .pop(pop), .pop_valid(pop_valid), .pop_op(pop_op)
  );

  // execute against the frame
  rfeu_back #(.FRAME_REGS(FRAME_REGS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(pop_valid), .q_op(pop_op), .q_pop(pop),
    .clr_busy(clr_busy),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_result_value(out_result_value)
  );

endmodule
`default_nettype wire

### sv/rfeu_checker.sv
// ----------------------------------------------------------------------------
// rfeu_checker: port-level checks of the execute unit
// Watches the top-level ports and flags result and reset misbehavior.
// ----------------------------------------------------------------------------
`default_nettype none
module rfeu_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  out_status,
  input wire [63:0] out_result_value
);

  // hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == rfeu_pkg::ST_DIVZ) ||
                  (out_status == rfeu_pkg::ST_RANGE)) |-> out_result_value == 64'd0)
    else $error("error result with nonzero value");

  // no result right after reset
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // intake closed right after reset
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("intake open during frame clear");

endmodule

bind register_frame_execute_unit rfeu_checker u_rfeu_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_status(out_status), .out_result_value(out_result_value)
);
`default_nettype wire
